[sv/assert_macros.svh]
// Assertion macros used by the checker file of the probe engine.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked at every rising edge of clk outside reset.
`define EPSE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("%m: check failed");
// Consequent must hold in the cycle after the antecedent.
`define EPSE_ASSERT_NEXT(lbl, ante, cons) \
	`EPSE_ASSERT(lbl, (ante) |=> (cons))
`endif

[sv/epse_pkg.sv]
// Package of the EAPOL-Start probe engine: codes, frame constants, the
// command type passed from front to back, and the start frame byte table.
package epse_pkg;

	typedef enum logic [1:0] {
		OpStart  = 2'd0,
		OpRxByte = 2'd1,
		OpTick   = 2'd2
	} op_t;

	localparam logic KindTx     = 1'b0;
	localparam logic KindReport = 1'b1;

	localparam logic [1:0] RegOwnMac   = 2'd0;
	localparam logic [1:0] RegTimeout  = 2'd1;
	localparam logic [1:0] RegInterval = 2'd2;
	localparam logic [1:0] RegMaxSends = 2'd3;

	localparam logic [15:0] EthertypePae = 16'h888E;
	localparam logic [7:0]  EapolPacket  = 8'd0;
	localparam logic [7:0]  EapRequest   = 8'd1;
	localparam logic [7:0]  EapSuccess   = 8'd3;
	localparam logic [7:0]  EapFailure   = 8'd4;

	localparam logic [4:0] FrameLastIdx = 5'd17;
	localparam logic [4:0] OffsetMax    = 5'd31;
	localparam logic [4:0] MinFrameLen  = 5'd18;
	localparam logic [4:0] EapFrameLen  = 5'd22;
	localparam logic [4:0] MethodLen    = 5'd23;

	localparam int QueueDepth = 4;

	typedef struct packed {
		logic [47:0] own_mac;
		logic [15:0] probe_timeout;
		logic [15:0] resend_interval_ms;
		logic [1:0]  max_sends;
	} cfg_t;

	// One unit of back-end work: either a whole start frame or one report.
	typedef struct packed {
		logic        is_report;
		logic [3:0]  flags;
		logic [7:0]  method;
		logic [15:0] count;
		logic [47:0] peer_mac;
	} cmd_t;

	function automatic logic [7:0] frame_byte(input logic [4:0] idx, input logic [47:0] mac);
		logic [7:0] b;
		case (idx)
			5'd0:  b = 8'h01;
			5'd1:  b = 8'h80;
			5'd2:  b = 8'hC2;
			5'd3:  b = 8'h00;
			5'd4:  b = 8'h00;
			5'd5:  b = 8'h03;
			5'd6:  b = mac[47:40];
			5'd7:  b = mac[39:32];
			5'd8:  b = mac[31:24];
			5'd9:  b = mac[23:16];
			5'd10: b = mac[15:8];
			5'd11: b = mac[7:0];
			5'd12: b = EthertypePae[15:8];
			5'd13: b = EthertypePae[7:0];
			5'd14: b = 8'h01;
			5'd15: b = 8'h01;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

[sv/epse_if.sv]
// Valid/ready channel interfaces of the probe engine: input items and results.
// Standalone; no package dependency.
interface epse_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] rx_byte;
	logic       rx_last;

	modport source (output valid, output operation, output rx_byte, output rx_last,
		input ready);
	modport sink (input valid, input operation, input rx_byte, input rx_last,
		output ready);
endinterface

interface epse_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  tx_byte;
	logic        last;
	logic        eapol_seen;
	logic        got_request;
	logic        got_success;
	logic        got_failure;
	logic [7:0]  eap_method;
	logic [15:0] frames_counted;
	logic [47:0] authenticator_mac;

	modport source (output valid, output kind, output tx_byte, output last,
		output eapol_seen, output got_request, output got_success, output got_failure,
		output eap_method, output frames_counted, output authenticator_mac,
		input ready);
	modport sink (input valid, input kind, input tx_byte, input last,
		input eapol_seen, input got_request, input got_success, input got_failure,
		input eap_method, input frames_counted, input authenticator_mac,
		output ready);
endinterface

[sv/epse_front.sv]
// Front end of the probe engine: accepts requests, parses received frames,
// runs the probe timers and pushes start-frame or report commands. Uses epse_pkg.
module epse_front (
	input  logic            clk,
	input  logic            arst_n,
	epse_in_if.sink         in_ch,
	input  epse_pkg::cfg_t  cfg,
	input  logic            q_full,
	output logic            push,
	output epse_pkg::cmd_t  push_cmd
);

	logic        probe_active_q, active_n;
	logic [15:0] elapsed_q, elapsed_n, elapsed_inc;
	logic [1:0]  sends_q, sends_n;
	logic [4:0]  offset_q, offset_n, offset_inc;
	logic [47:0] src_mac_q, src_mac_n, src_cap;
	logic [15:0] ethertype_q, ethertype_n, eth_cap;
	logic [7:0]  eapol_type_q, eapol_type_n, etype_cap;
	logic [15:0] body_len_q, body_len_n, body_cap;
	logic [7:0]  eap_code_q, eap_code_n, code_cap;
	logic [7:0]  eap_type_q, eap_type_n, mtype_cap;
	logic [3:0]  flags_q, flags_n;
	logic [7:0]  method_q, method_n;
	logic [15:0] count_q, count_n;
	logic [47:0] peer_mac_q, peer_mac_n;
	logic [17:0] resend_at;
	logic        accept;
	logic        want_push;

	assign in_ch.ready = !q_full;
	assign accept = in_ch.valid && in_ch.ready;
	assign push = accept && want_push;

	assign offset_inc = (offset_q == epse_pkg::OffsetMax) ? offset_q : offset_q + 5'd1;
	assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
	// sends_q is at most 3, so the product is two shifted adds.
	assign resend_at = ({2'b00, cfg.resend_interval_ms} & {18{sends_q[0]}})
		+ ({1'b0, cfg.resend_interval_ms, 1'b0} & {18{sends_q[1]}});

	always_comb begin
		src_cap   = src_mac_q;
		eth_cap   = ethertype_q;
		etype_cap = eapol_type_q;
		body_cap  = body_len_q;
		code_cap  = eap_code_q;
		mtype_cap = eap_type_q;
		case (offset_q)
			5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11:
				src_cap = {src_mac_q[39:0], in_ch.rx_byte};
			5'd12, 5'd13: eth_cap = {ethertype_q[7:0], in_ch.rx_byte};
			5'd15: etype_cap = in_ch.rx_byte;
			5'd16, 5'd17: body_cap = {body_len_q[7:0], in_ch.rx_byte};
			5'd18: code_cap = in_ch.rx_byte;
			5'd22: mtype_cap = in_ch.rx_byte;
			default: ;
		endcase
	end

	always_comb begin
		active_n     = probe_active_q;
		elapsed_n    = elapsed_q;
		sends_n      = sends_q;
		offset_n     = offset_q;
		src_mac_n    = src_mac_q;
		ethertype_n  = ethertype_q;
		eapol_type_n = eapol_type_q;
		body_len_n   = body_len_q;
		eap_code_n   = eap_code_q;
		eap_type_n   = eap_type_q;
		flags_n      = flags_q;
		method_n     = method_q;
		count_n      = count_q;
		peer_mac_n   = peer_mac_q;
		want_push    = 1'b0;
		push_cmd.is_report = epse_pkg::KindTx;
		case (epse_pkg::op_t'(in_ch.operation))
			epse_pkg::OpStart: begin
				flags_n      = '0;
				method_n     = '0;
				count_n      = '0;
				peer_mac_n   = '0;
				offset_n     = '0;
				src_mac_n    = '0;
				ethertype_n  = '0;
				eapol_type_n = '0;
				body_len_n   = '0;
				eap_code_n   = '0;
				eap_type_n   = '0;
				active_n     = 1'b1;
				elapsed_n    = '0;
				sends_n      = 2'd1;
				want_push    = 1'b1;
			end
			epse_pkg::OpRxByte: begin
				offset_n     = offset_inc;
				src_mac_n    = src_cap;
				ethertype_n  = eth_cap;
				eapol_type_n = etype_cap;
				body_len_n   = body_cap;
				eap_code_n   = code_cap;
				eap_type_n   = mtype_cap;
				if (in_ch.rx_last) begin
					if (probe_active_q && offset_inc >= epse_pkg::MinFrameLen
							&& eth_cap == epse_pkg::EthertypePae) begin
						if (count_q != 16'hFFFF) count_n = count_q + 16'd1;
						flags_n[0] = 1'b1;
						peer_mac_n = src_cap;
						if (etype_cap == epse_pkg::EapolPacket && body_cap >= 16'd4
								&& offset_inc >= epse_pkg::EapFrameLen) begin
							if (code_cap == epse_pkg::EapRequest) begin
								flags_n[1] = 1'b1;
								if (body_cap >= 16'd5 && offset_inc >= epse_pkg::MethodLen)
									method_n = mtype_cap;
							end else if (code_cap == epse_pkg::EapSuccess) begin
								flags_n[2] = 1'b1;
							end else if (code_cap == epse_pkg::EapFailure) begin
								flags_n[3] = 1'b1;
							end
						end
					end
					offset_n     = '0;
					src_mac_n    = '0;
					ethertype_n  = '0;
					eapol_type_n = '0;
					body_len_n   = '0;
					eap_code_n   = '0;
					eap_type_n   = '0;
					if (probe_active_q && flags_n[3:1] != 3'b000) begin
						active_n  = 1'b0;
						want_push = 1'b1;
						push_cmd.is_report = epse_pkg::KindReport;
					end
				end
			end
			epse_pkg::OpTick: begin
				if (probe_active_q) begin
					elapsed_n = elapsed_inc;
					if (elapsed_inc >= cfg.probe_timeout) begin
						active_n  = 1'b0;
						want_push = 1'b1;
						push_cmd.is_report = epse_pkg::KindReport;
					end else if (sends_q < cfg.max_sends
							&& {2'b00, elapsed_inc} > resend_at) begin
						sends_n   = sends_q + 2'd1;
						want_push = 1'b1;
					end
				end
			end
			default: ;
		endcase
		push_cmd.flags    = flags_n;
		push_cmd.method   = method_n;
		push_cmd.count    = count_n;
		push_cmd.peer_mac = peer_mac_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_active_q <= 1'b0;
			elapsed_q      <= '0;
			sends_q        <= '0;
			offset_q       <= '0;
			src_mac_q      <= '0;
			ethertype_q    <= '0;
			eapol_type_q   <= '0;
			body_len_q     <= '0;
			eap_code_q     <= '0;
			eap_type_q     <= '0;
			flags_q        <= '0;
			method_q       <= '0;
			count_q        <= '0;
			peer_mac_q     <= '0;
		end else if (accept) begin
			probe_active_q <= active_n;
			elapsed_q      <= elapsed_n;
			sends_q        <= sends_n;
			offset_q       <= offset_n;
			src_mac_q      <= src_mac_n;
			ethertype_q    <= ethertype_n;
			eapol_type_q   <= eapol_type_n;
			body_len_q     <= body_len_n;
			eap_code_q     <= eap_code_n;
			eap_type_q     <= eap_type_n;
			flags_q        <= flags_n;
			method_q       <= method_n;
			count_q        <= count_n;
			peer_mac_q     <= peer_mac_n;
		end
	end

endmodule

[sv/epse_cmd_queue.sv]
// Short command queue between the front and back ends of the probe engine.
// Register-based FIFO of epse_pkg::cmd_t entries.
module epse_cmd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  epse_pkg::cmd_t  push_cmd,
	input  logic            pop,
	output epse_pkg::cmd_t  head,
	output logic            head_valid,
	output logic            full
);

	localparam int PtrW = $clog2(epse_pkg::QueueDepth);
	localparam int CntW = $clog2(epse_pkg::QueueDepth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(epse_pkg::QueueDepth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(epse_pkg::QueueDepth);

	epse_pkg::cmd_t entries_q [epse_pkg::QueueDepth];
	logic [PtrW-1:0] rd_q, wr_q;
	logic [CntW-1:0] count_q;

	assign full = (count_q == CntFull);
	assign head_valid = (count_q != '0);
	assign head = entries_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) entries_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q    <= '0;
			wr_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

[sv/epse_back.sv]
// Back end of the probe engine: expands queued commands into result items,
// 18 frame bytes or one report, into an output register. Uses epse_pkg.
module epse_back (
	input  logic            clk,
	input  logic            arst_n,
	input  epse_pkg::cmd_t  head,
	input  logic            head_valid,
	input  logic [47:0]     own_mac,
	output logic            pop,
	epse_out_if.source      out_ch
);

	logic        out_valid_q;
	logic [4:0]  idx_q;
	logic        advance;
	logic        kind_q, last_q;
	logic [7:0]  tx_byte_q;
	logic [3:0]  flags_q;
	logic [7:0]  method_q;
	logic [15:0] count_q;
	logic [47:0] mac_q;

	assign advance = !out_valid_q || out_ch.ready;
	assign pop = advance && head_valid && (head.is_report || idx_q == epse_pkg::FrameLastIdx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (advance) begin
			out_valid_q <= head_valid;
			if (head_valid && !head.is_report)
				idx_q <= (idx_q == epse_pkg::FrameLastIdx) ? '0 : idx_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && head_valid) begin
			if (head.is_report) begin
				kind_q    <= epse_pkg::KindReport;
				tx_byte_q <= '0;
				last_q    <= 1'b1;
				flags_q   <= head.flags;
				method_q  <= head.method;
				count_q   <= head.count;
				mac_q     <= head.peer_mac;
			end else begin
				kind_q    <= epse_pkg::KindTx;
				tx_byte_q <= epse_pkg::frame_byte(idx_q, own_mac);
				last_q    <= (idx_q == epse_pkg::FrameLastIdx);
				flags_q   <= '0;
				method_q  <= '0;
				count_q   <= '0;
				mac_q     <= '0;
			end
		end
	end

	assign out_ch.valid             = out_valid_q;
	assign out_ch.kind              = kind_q;
	assign out_ch.tx_byte           = tx_byte_q;
	assign out_ch.last              = last_q;
	assign out_ch.eapol_seen        = flags_q[0];
	assign out_ch.got_request       = flags_q[1];
	assign out_ch.got_success       = flags_q[2];
	assign out_ch.got_failure       = flags_q[3];
	assign out_ch.eap_method        = method_q;
	assign out_ch.frames_counted    = count_q;
	assign out_ch.authenticator_mac = mac_q;

endmodule

[sv/eapol_start_probe_engine_unit.sv]
// Requests are taken in the cycle they are offered while the 4-entry command queue
// has room; its result passes a queue entry and then the output register.
// Throughput: one request per cycle while the queue has room; the back end sends one
// result per cycle while the sink is ready; a frame is 18 items, a report one.
// Reset: arst_n clears all control state and loads the register reset values.
module eapol_start_probe_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	epse_in_if.sink     in_ch,
	epse_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	epse_pkg::cfg_t cfg_q;
	epse_pkg::cmd_t push_cmd, head;
	logic push, pop, head_valid, q_full;
	logic cfg_write;

	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_mac            <= '0;
			cfg_q.probe_timeout      <= 16'd5000;
			cfg_q.resend_interval_ms <= 16'd1000;
			cfg_q.max_sends          <= 2'd3;
		end else if (cfg_write) begin
			case (paddr[4:3])
				epse_pkg::RegOwnMac:   cfg_q.own_mac <= pwdata[47:0];
				epse_pkg::RegTimeout:  cfg_q.probe_timeout <= pwdata[15:0];
				epse_pkg::RegInterval: cfg_q.resend_interval_ms <= pwdata[15:0];
				epse_pkg::RegMaxSends: cfg_q.max_sends <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			epse_pkg::RegOwnMac:   prdata = {16'b0, cfg_q.own_mac};
			epse_pkg::RegTimeout:  prdata = {48'b0, cfg_q.probe_timeout};
			epse_pkg::RegInterval: prdata = {48'b0, cfg_q.resend_interval_ms};
			epse_pkg::RegMaxSends: prdata = {62'b0, cfg_q.max_sends};
			default:               prdata = '0;
		endcase
	end

	epse_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	epse_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (q_full)
	);

	epse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.own_mac    (cfg_q.own_mac),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule

[sv/epse_checker.sv]
// Port-level checks of the probe engine result channel, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module epse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        kind,
	input logic [7:0]  tx_byte,
	input logic        last,
	input logic        eapol_seen,
	input logic        got_request,
	input logic        got_success,
	input logic        got_failure,
	input logic [15:0] frames_counted
);

	// A report always closes its burst and carries no frame byte.
	`EPSE_ASSERT(a_report_shape, out_valid && kind |-> last && tx_byte == 8'd0)
	// Frame bytes carry no report content.
	`EPSE_ASSERT(a_tx_clean, out_valid && !kind |-> !eapol_seen && !got_request && !got_success && !got_failure && frames_counted == 16'd0)
	// Any counted frame or EAP answer implies an EAPOL frame was seen.
	`EPSE_ASSERT(a_seen_implied, out_valid && kind && (frames_counted != 16'd0 || got_request || got_success || got_failure) |-> eapol_seen)
	// A stalled result stays put.
	`EPSE_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(tx_byte) && $stable(last))

endmodule

bind eapol_start_probe_engine_unit epse_checker u_epse_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.kind           (out_ch.kind),
	.tx_byte        (out_ch.tx_byte),
	.last           (out_ch.last),
	.eapol_seen     (out_ch.eapol_seen),
	.got_request    (out_ch.got_request),
	.got_success    (out_ch.got_success),
	.got_failure    (out_ch.got_failure),
	.frames_counted (out_ch.frames_counted)
);

[tb/sv/tb_top.sv]
// Testbench of the EAPOL-Start probe engine: directed and random probes with
// checking of every transmitted byte and report. Depends on epse_pkg, on the
// channel interfaces in epse_if.sv and on eapol_start_probe_engine_unit.
module tb_top;

	localparam logic [47:0] PaeGroupAddr = 48'h0180_C200_0003;
	localparam int RandomStop = 280;
	localparam int SteadyItems = 20;

	typedef struct {
		logic        kind;
		logic [7:0]  tx_byte;
		logic        last;
		logic [3:0]  flags;
		logic [7:0]  method;
		logic [15:0] count;
		logic [47:0] mac;
	} probe_out_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	epse_in_if  in_ch ();
	epse_out_if out_ch ();

	eapol_start_probe_engine_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Register copies and probe state as the engine should hold them.
	logic [47:0] cfg_mac;
	logic [15:0] cfg_timeout;
	logic [15:0] cfg_interval;
	logic [1:0]  cfg_max_sends;
	logic        armed;
	logic [15:0] ms_elapsed;
	logic [1:0]  starts_sent;
	logic [4:0]  rx_pos;
	logic [47:0] rx_src;
	logic [15:0] rx_etype;
	logic [7:0]  rx_eapol_type;
	logic [15:0] rx_body_len;
	logic [7:0]  rx_code;
	logic [7:0]  rx_method;
	logic [3:0]  seen_flags;
	logic [7:0]  kept_method;
	logic [15:0] eapol_frames;
	logic [47:0] kept_peer_mac;

	probe_out_t frames_and_reports[$];
	int         mismatches = 0;
	int         items_sent = 0;
	bit         idling_on = 1'b1;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic void clear_rx_header();
		rx_pos = '0;
		rx_src = '0;
		rx_etype = '0;
		rx_eapol_type = '0;
		rx_body_len = '0;
		rx_code = '0;
		rx_method = '0;
	endfunction

	function automatic void reset_probe_copy();
		cfg_mac = '0;
		cfg_timeout = 16'd5000;
		cfg_interval = 16'd1000;
		cfg_max_sends = 2'd3;
		armed = 1'b0;
		ms_elapsed = '0;
		starts_sent = '0;
		clear_rx_header();
		seen_flags = '0;
		kept_method = '0;
		eapol_frames = '0;
		kept_peer_mac = '0;
	endfunction

	function automatic void queue_start_frame();
		probe_out_t r;
		for (int k = 0; k < 18; k++) begin
			r = '{default: '0};
			r.kind = epse_pkg::KindTx;
			if (k < 6)
				r.tx_byte = PaeGroupAddr[8*(5-k) +: 8];
			else if (k < 12)
				r.tx_byte = cfg_mac[8*(11-k) +: 8];
			else if (k == 12)
				r.tx_byte = epse_pkg::EthertypePae[15:8];
			else if (k == 13)
				r.tx_byte = epse_pkg::EthertypePae[7:0];
			else if (k < 16)
				r.tx_byte = 8'h01;
			else
				r.tx_byte = 8'h00;
			r.last = (k == epse_pkg::FrameLastIdx);
			frames_and_reports.push_back(r);
		end
	endfunction

	function automatic void queue_report();
		probe_out_t r;
		r.kind = epse_pkg::KindReport;
		r.tx_byte = '0;
		r.last = 1'b1;
		r.flags = seen_flags;
		r.method = kept_method;
		r.count = eapol_frames;
		r.mac = kept_peer_mac;
		frames_and_reports.push_back(r);
		armed = 1'b0;
	endfunction

	function automatic void judge_frame(logic [4:0] len);
		if (len < epse_pkg::MinFrameLen || rx_etype != epse_pkg::EthertypePae)
			return;
		if (eapol_frames != 16'hFFFF)
			eapol_frames++;
		seen_flags[0] = 1'b1;
		kept_peer_mac = rx_src;
		if (rx_eapol_type == epse_pkg::EapolPacket && rx_body_len >= 16'd4
				&& len >= epse_pkg::EapFrameLen) begin
			if (rx_code == epse_pkg::EapRequest) begin
				seen_flags[1] = 1'b1;
				if (rx_body_len >= 16'd5 && len >= epse_pkg::MethodLen)
					kept_method = rx_method;
			end else if (rx_code == epse_pkg::EapSuccess) begin
				seen_flags[2] = 1'b1;
			end else if (rx_code == epse_pkg::EapFailure) begin
				seen_flags[3] = 1'b1;
			end
		end
	endfunction

	function automatic void advance_probe(epse_pkg::op_t op, logic [7:0] b, logic lst);
		int lim;
		case (op)
			epse_pkg::OpStart: begin
				seen_flags = '0;
				kept_method = '0;
				eapol_frames = '0;
				kept_peer_mac = '0;
				clear_rx_header();
				armed = 1'b1;
				ms_elapsed = '0;
				starts_sent = 2'd1;
				queue_start_frame();
			end
			epse_pkg::OpRxByte: begin
				if (rx_pos >= 5'd6 && rx_pos <= 5'd11)
					rx_src = {rx_src[39:0], b};
				else if (rx_pos == 5'd12 || rx_pos == 5'd13)
					rx_etype = {rx_etype[7:0], b};
				else if (rx_pos == 5'd15)
					rx_eapol_type = b;
				else if (rx_pos == 5'd16 || rx_pos == 5'd17)
					rx_body_len = {rx_body_len[7:0], b};
				else if (rx_pos == 5'd18)
					rx_code = b;
				else if (rx_pos == 5'd22)
					rx_method = b;
				if (rx_pos != epse_pkg::OffsetMax)
					rx_pos++;
				if (!lst)
					return;
				if (armed)
					judge_frame(rx_pos);
				clear_rx_header();
				if (armed && seen_flags[3:1] != 3'b000)
					queue_report();
			end
			epse_pkg::OpTick: begin
				if (!armed)
					return;
				if (ms_elapsed != 16'hFFFF)
					ms_elapsed++;
				lim = int'(starts_sent) * int'(cfg_interval);
				if (ms_elapsed >= cfg_timeout) begin
					queue_report();
				end else if (starts_sent < cfg_max_sends && int'(ms_elapsed) > lim) begin
					starts_sent++;
					queue_start_frame();
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		probe_out_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (frames_and_reports.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0h byte %0h",
					$time, out_ch.kind, out_ch.tx_byte);
				mismatches++;
			end else begin
				want = frames_and_reports.pop_front();
				compare_field("kind", 64'(want.kind), 64'(out_ch.kind));
				compare_field("tx_byte", 64'(want.tx_byte), 64'(out_ch.tx_byte));
				compare_field("last", 64'(want.last), 64'(out_ch.last));
				compare_field("eapol_seen", 64'(want.flags[0]), 64'(out_ch.eapol_seen));
				compare_field("got_request", 64'(want.flags[1]), 64'(out_ch.got_request));
				compare_field("got_success", 64'(want.flags[2]), 64'(out_ch.got_success));
				compare_field("got_failure", 64'(want.flags[3]), 64'(out_ch.got_failure));
				compare_field("eap_method", 64'(want.method), 64'(out_ch.eap_method));
				compare_field("frames_counted", 64'(want.count), 64'(out_ch.frames_counted));
				compare_field("authenticator_mac", 64'(want.mac),
					64'(out_ch.authenticator_mac));
			end
		end
	end

	// The result sink stalls in bursts while idling is on.
	initial begin
		out_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (idling_on && $urandom_range(0, 2) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	task automatic send_item(input epse_pkg::op_t op, input logic [7:0] b, input logic lst);
		if (idling_on && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.operation <= op;
		in_ch.rx_byte <= b;
		in_ch.rx_last <= lst;
		do @(posedge clk); while (!in_ch.ready);
		advance_probe(op, b, lst);
		items_sent++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			epse_pkg::RegOwnMac:   cfg_mac = val[47:0];
			epse_pkg::RegTimeout:  cfg_timeout = val[15:0];
			epse_pkg::RegInterval: cfg_interval = val[15:0];
			epse_pkg::RegMaxSends: cfg_max_sends = val[1:0];
			default: ;
		endcase
	endtask

	// Registers change only once every result is out and a trailing byte has settled.
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (frames_and_reports.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_probe_regs(input logic [47:0] mac, input logic [15:0] tmo,
			input logic [15:0] ivl, input logic [1:0] sends);
		settle();
		write_reg(epse_pkg::RegOwnMac, {16'h0, mac});
		write_reg(epse_pkg::RegTimeout, {48'h0, tmo});
		write_reg(epse_pkg::RegInterval, {48'h0, ivl});
		write_reg(epse_pkg::RegMaxSends, {62'h0, sends});
	endtask

	task automatic send_frame(input int len, input logic [15:0] etype, input logic [7:0] ptype,
			input logic [15:0] blen, input logic [7:0] code, input logic [7:0] method,
			input logic [47:0] src, input bit terminated);
		logic [7:0] fb;
		for (int k = 0; k < len; k++) begin
			fb = 8'($urandom);
			if (k >= 6 && k <= 11)
				fb = src[8*(11-k) +: 8];
			else if (k == 12)
				fb = etype[15:8];
			else if (k == 13)
				fb = etype[7:0];
			else if (k == 15)
				fb = ptype;
			else if (k == 16)
				fb = blen[15:8];
			else if (k == 17)
				fb = blen[7:0];
			else if (k == 18)
				fb = code;
			else if (k == 22)
				fb = method;
			send_item(epse_pkg::OpRxByte, fb, terminated && k == len - 1);
		end
	endtask

	task automatic send_start();
		send_item(epse_pkg::OpStart, 8'($urandom), 1'($urandom_range(0, 1)));
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_item(epse_pkg::OpTick, 8'($urandom), 1'($urandom_range(0, 1)));
	endtask

	task automatic send_random_frame(input bit terminated);
		int          len;
		int          sel;
		logic [15:0] etype;
		logic [15:0] blen;
		logic [7:0]  ptype;
		logic [7:0]  code;
		logic [63:0] r64;
		sel = $urandom_range(0, 9);
		len = (sel == 0) ? int'($urandom_range(1, 17)) :
			(sel == 1) ? int'($urandom_range(27, 36)) : int'($urandom_range(18, 24));
		etype = ($urandom_range(0, 6) == 0) ? 16'($urandom) : epse_pkg::EthertypePae;
		ptype = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) : epse_pkg::EapolPacket;
		case ($urandom_range(0, 5))
			0: blen = 16'($urandom_range(0, 3));
			1: blen = 16'($urandom);
			2: blen = 16'd4;
			3: blen = 16'd5;
			default: blen = 16'($urandom_range(4, 40));
		endcase
		case ($urandom_range(0, 7))
			0, 1, 2: code = epse_pkg::EapRequest;
			3: code = epse_pkg::EapSuccess;
			4: code = epse_pkg::EapFailure;
			5: code = 8'd2;
			default: code = 8'($urandom);
		endcase
		r64 = {$urandom, $urandom};
		send_frame(len, etype, ptype, blen, code, 8'($urandom), r64[47:0], terminated);
	endtask

	// One probe with random frames, ticks and restarts mixed in.
	task automatic run_probe_episode(input int stop_at);
		send_start();
		repeat ($urandom_range(3, 10)) begin
			if (items_sent < stop_at) begin
				case ($urandom_range(0, 9))
					0: send_start();
					1: send_random_frame(1'b0);
					2, 3, 4, 5: send_random_frame(1'b1);
					default: send_ticks($urandom_range(1, 6));
				endcase
			end
		end
	endtask

	task automatic pick_random_regs();
		logic [63:0] r64;
		logic [47:0] mac;
		logic [15:0] tmo;
		logic [15:0] ivl;
		r64 = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: mac = '0;
			1: mac = '1;
			default: mac = r64[47:0];
		endcase
		case ($urandom_range(0, 5))
			0: tmo = 16'd1;
			1: tmo = 16'hFFFF;
			default: tmo = 16'($urandom_range(2, 40));
		endcase
		case ($urandom_range(0, 5))
			0: ivl = 16'd1;
			1: ivl = 16'hFFFF;
			default: ivl = 16'($urandom_range(1, 12));
		endcase
		set_probe_regs(mac, tmo, ivl, 2'($urandom_range(1, 3)));
	endtask

	task automatic test_reset_defaults();
		send_start();
		send_frame(22, epse_pkg::EthertypePae, epse_pkg::EapolPacket, 16'd4,
			epse_pkg::EapSuccess, 8'h00, 48'h0011_2233_4455, 1'b1);
	endtask

	task automatic test_register_extremes();
		set_probe_regs('1, 16'd1, 16'd1, 2'd1);
		send_start();
		send_ticks(1);
		// Ticks and frames after the probe has ended change nothing.
		send_ticks(1);
		send_frame(6, epse_pkg::EthertypePae, epse_pkg::EapolPacket, 16'd4,
			epse_pkg::EapSuccess, 8'h00, '1, 1'b1);
		set_probe_regs(48'hA55A_0FF0_1234, 16'hFFFF, 16'hFFFF, 2'd3);
		send_start();
		send_ticks(3);
	endtask

	task automatic test_resend_timing();
		set_probe_regs(48'h0200_0000_0001, 16'd4, 16'd1, 2'd3);
		send_start();
		send_ticks(4);
		set_probe_regs(48'h0200_0000_0002, 16'd6, 16'd2, 2'd2);
		send_start();
		send_ticks(6);
	endtask

	task automatic test_eap_answers();
		set_probe_regs(48'h0A0B_0C0D_0E0F, 16'hFFFF, 16'hFFFF, 2'd1);
		send_start();
		send_frame(17, epse_pkg::EthertypePae, epse_pkg::EapolPacket, 16'd4,
			epse_pkg::EapSuccess, 8'h00, 48'h1, 1'b1);
		send_frame(18, epse_pkg::EthertypePae, 8'd1, 16'd0, 8'h00, 8'h00,
			48'h0102_0304_0506, 1'b1);
		send_frame(22, epse_pkg::EthertypePae, epse_pkg::EapolPacket, 16'd4,
			epse_pkg::EapRequest, 8'h19, 48'hFEDC_BA98_7654, 1'b1);
		send_start();
		send_frame(23, epse_pkg::EthertypePae, epse_pkg::EapolPacket, 16'd5,
			epse_pkg::EapRequest, 8'h2B, '1, 1'b1);
		send_start();
		send_frame(22, epse_pkg::EthertypePae, epse_pkg::EapolPacket, 16'd5,
			epse_pkg::EapRequest, 8'h0D, 48'h5, 1'b1);
		send_start();
		// Bytes past the capture window only extend the length.
		send_frame(35, epse_pkg::EthertypePae, epse_pkg::EapolPacket, 16'hFFFF,
			epse_pkg::EapFailure, 8'hFF, 48'h7, 1'b1);
		send_start();
		send_frame(20, epse_pkg::EthertypePae, epse_pkg::EapolPacket, 16'd4,
			epse_pkg::EapSuccess, 8'h00, 48'h8, 1'b0);
		send_start();
		send_frame(22, 16'h0800, epse_pkg::EapolPacket, 16'd4, epse_pkg::EapSuccess,
			8'h00, 48'h9, 1'b1);
		send_frame(22, epse_pkg::EthertypePae, epse_pkg::EapolPacket, 16'd3,
			epse_pkg::EapSuccess, 8'h00, 48'hA, 1'b1);
		send_frame(22, epse_pkg::EthertypePae, epse_pkg::EapolPacket, 16'd4,
			epse_pkg::EapSuccess, 8'h00, 48'hB, 1'b1);
	endtask

	task automatic test_random_probes();
		do begin
			pick_random_regs();
			repeat ($urandom_range(1, 3)) run_probe_episode(RandomStop);
		end while (items_sent < RandomStop);
	endtask

	task automatic test_steady_flow();
		int stop_at;
		settle();
		idling_on = 1'b0;
		pick_random_regs();
		stop_at = items_sent + SteadyItems;
		repeat (2) run_probe_episode(stop_at);
	endtask

	initial begin
		reset_probe_copy();
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.operation <= epse_pkg::OpStart;
		in_ch.rx_byte <= '0;
		in_ch.rx_last <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_resend_timing();
		test_eap_answers();
		test_random_probes();
		test_steady_flow();

		settle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && frames_and_reports.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
